FILE: hw/rtl/round_robin_run_queue_macros.svh
// Assertion macros for the round-robin run queue.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef ROUND_ROBIN_RUN_QUEUE_MACROS_SVH
`define ROUND_ROBIN_RUN_QUEUE_MACROS_SVH
`ifndef ASSERT_OFF
// Plain invariant, checked at every clock edge outside reset.
`define RRQ_ASSERT(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("run queue invariant violated");
// Same-cycle implication.
`define RRQ_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("run queue implication violated");
// Next-cycle implication.
`define RRQ_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("run queue sequence violated");
`else
`define RRQ_ASSERT(lbl, clk, rst_n, expr)
`define RRQ_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define RRQ_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

FILE: hw/rtl/rrq_pkg.sv
// Shared types and constants of the round-robin run queue.
// No dependencies; imported by rrq_flags and round_robin_run_queue.
`default_nettype none

package rrq_pkg;

	localparam int unsigned TID_W = 6;
	localparam int unsigned CMD_W = 2;
	localparam int unsigned ST_W = 2;
	localparam int unsigned MAX_THREADS_DEF = 64;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd2;

	// Status codes.
	localparam logic [ST_W-1:0] ST_OK = 2'd0;
	localparam logic [ST_W-1:0] ST_NOT_QUEUED = 2'd1;
	localparam logic [ST_W-1:0] ST_ALREADY_QUEUED = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [TID_W-1:0] thread_id;
	} rrq_req_t;

	typedef struct packed {
		logic [ST_W-1:0] status;
		logic running_valid;
		logic [TID_W-1:0] running_id;
	} rrq_rsp_t;

	// Set and clear of queued flags in one cycle (ids always differ).
	typedef struct packed {
		logic set_en;
		logic [TID_W-1:0] set_id;
		logic clr_en;
		logic [TID_W-1:0] clr_id;
	} rrq_flag_upd_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rrq_flags.sv
// Queued-flag bit vector of the run queue: one flip-flop per thread, cleared by reset.
// Depends on rrq_pkg for the update struct and the thread id width.
`default_nettype none

module rrq_flags #(
	parameter int unsigned DEPTH = rrq_pkg::MAX_THREADS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire rrq_pkg::rrq_flag_upd_t upd,
	input wire logic [rrq_pkg::TID_W-1:0] look_id,
	output logic hit
);
	import rrq_pkg::*;

	localparam int unsigned FlagW = $clog2(DEPTH);

	logic [DEPTH-1:0] flags_q;
	logic look_in_range;

	// Flag updates: clear the thread leaving, set the thread entering.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else begin
			if (upd.clr_en) begin
				flags_q[FlagW'(upd.clr_id)] <= 1'b0;
			end
			if (upd.set_en) begin
				flags_q[FlagW'(upd.set_id)] <= 1'b1;
			end
		end
	end

	// Lookup; identities beyond the table are never queued.
	assign look_in_range = (32'(look_id) < DEPTH);
	assign hit = look_in_range && flags_q[FlagW'(look_id)];

endmodule

`default_nettype wire

FILE: hw/rtl/round_robin_run_queue.sv
// Round-robin run queue: a FIFO of thread ids kept as a next-link table plus one running thread.
// Depends on rrq_pkg, rrq_flags and round_robin_run_queue_macros.svh.
//
// Requests enter on req (command, thread_id) with req_valid/req_stall; each request gives
// exactly one response on rsp (status, running_valid, running_id) with rsp_valid/rsp_stall.
// A request is taken only while no earlier request is being worked on; req_stall is high
// from acceptance until the response has been loaded into the output register.
// Add, a rejected request and an unused command go from S_EXEC straight to S_RESP.
// Schedule and remove of the head pass through S_POP when the head has a successor, to
// read that successor from the link memory. Remove of any other thread walks the links,
// one link memory read per cycle in S_WALK, and unlinks the thread in S_SPLICE once it is
// found; the link memory has a single read port.
// The output register holds a response while rsp_stall is high; a new request is still taken
// meanwhile, and its response waits in the final state until the register is free.
// Reset empties the queue, clears every queued flag and the running thread at once; the link
// memory needs no clearing, as only links that were written are ever followed.
`default_nettype none
`include "round_robin_run_queue_macros.svh"

module round_robin_run_queue #(
	parameter int unsigned MAX_THREADS = rrq_pkg::MAX_THREADS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire rrq_pkg::rrq_req_t req,
	output logic rsp_valid,
	input wire logic rsp_stall,
	output rrq_pkg::rrq_rsp_t rsp
);
	import rrq_pkg::*;

	// Only ids that fit the id field can ever be queued.
	localparam int unsigned N = (MAX_THREADS < (2 ** TID_W)) ? MAX_THREADS : (2 ** TID_W);
	localparam int unsigned IdW = $clog2(N);
	localparam int unsigned CntW = $clog2(N + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_WALK,
		S_SPLICE,
		S_RESP
	} state_t;

	state_t state_q;
	logic [CMD_W-1:0] cmd_q;
	logic [TID_W-1:0] tid_q;
	logic [ST_W-1:0] status_q;
	logic [IdW-1:0] head_q;
	logic [IdW-1:0] tail_q;
	logic [CntW-1:0] cnt_q;
	logic [IdW-1:0] cur_q;
	logic cur_valid_q;
	logic [IdW-1:0] walk_q;
	logic [CntW-1:0] steps_q;
	logic rsp_valid_q;
	rrq_rsp_t rsp_q;

	// Link memory and its registered read data.
	logic [IdW-1:0] link_mem [N];
	logic [IdW-1:0] rd_data_q;
	logic mem_we;
	logic [IdW-1:0] mem_waddr;
	logic [IdW-1:0] mem_wdata;
	logic mem_re;
	logic [IdW-1:0] mem_raddr;

	rrq_flag_upd_t flag_upd;
	logic flag_hit;

	logic [IdW-1:0] tid_ix;
	logic tid_in_range;
	logic tid_running;
	logic cnt_zero;
	logic cnt_gt1;
	logic rsp_free;

	assign tid_ix = IdW'(tid_q);
	assign tid_in_range = (32'(tid_q) < MAX_THREADS);
	assign tid_running = cur_valid_q && (TID_W'(cur_q) == tid_q);
	assign cnt_zero = (cnt_q == '0);
	assign cnt_gt1 = (cnt_q > CntW'(1));
	assign rsp_free = !rsp_valid_q || !rsp_stall;

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	rrq_flags #(
		.DEPTH(N)
	) u_flags (
		.clk(clk),
		.arst_n(arst_n),
		.upd(flag_upd),
		.look_id(tid_q),
		.hit(flag_hit)
	);

	// Memory accesses and flag updates for the current state.
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = tail_q;
		mem_wdata = tid_ix;
		mem_re = 1'b0;
		mem_raddr = head_q;
		flag_upd = '0;
		unique case (state_q)
			S_EXEC: begin
				unique case (cmd_q)
					CMD_ADD: begin
						if (tid_in_range && !flag_hit && !tid_running) begin
							mem_we = !cnt_zero;
							flag_upd.set_en = 1'b1;
							flag_upd.set_id = tid_q;
						end
					end
					CMD_REMOVE: begin
						if (tid_in_range && flag_hit) begin
							// Head removal pops; otherwise the walk starts at the head.
							mem_re = cnt_gt1;
							if (head_q == tid_ix || !cnt_gt1) begin
								flag_upd.clr_en = 1'b1;
								flag_upd.clr_id = tid_q;
							end
						end
					end
					CMD_SCHEDULE: begin
						if (!cnt_zero) begin
							flag_upd.clr_en = 1'b1;
							flag_upd.clr_id = TID_W'(head_q);
							mem_re = cnt_gt1;
							if (cur_valid_q) begin
								// Running thread goes behind the tail.
								mem_we = 1'b1;
								mem_wdata = cur_q;
								flag_upd.set_en = 1'b1;
								flag_upd.set_id = TID_W'(cur_q);
							end
						end
					end
					default: begin
					end
				endcase
			end
			S_WALK: begin
				if (rd_data_q == tid_ix) begin
					mem_re = 1'b1;
					mem_raddr = tid_ix;
				end else if ((steps_q + CntW'(1)) < cnt_q) begin
					mem_re = 1'b1;
					mem_raddr = rd_data_q;
				end else begin
					// Flag set but thread not on the chain: drop the stale flag.
					flag_upd.clr_en = 1'b1;
					flag_upd.clr_id = tid_q;
				end
			end
			S_SPLICE: begin
				mem_we = 1'b1;
				mem_waddr = walk_q;
				mem_wdata = rd_data_q;
				flag_upd.clr_en = 1'b1;
				flag_upd.clr_id = tid_q;
			end
			S_IDLE, S_POP, S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// Link memory: one write and one read per cycle, read data registered.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			link_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= link_mem[mem_raddr];
		end
	end

	// Sequencer, queue pointers, running thread and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cmd_q <= CMD_ADD;
			tid_q <= '0;
			status_q <= ST_OK;
			head_q <= '0;
			tail_q <= '0;
			cnt_q <= '0;
			cur_q <= '0;
			cur_valid_q <= 1'b0;
			walk_q <= '0;
			steps_q <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			// A response leaving the register is replaced directly when S_RESP loads the next.
			if (rsp_valid_q && !rsp_stall && state_q != S_RESP) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						cmd_q <= req.command;
						tid_q <= req.thread_id;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					status_q <= ST_OK;
					state_q <= S_RESP;
					unique case (cmd_q)
						CMD_ADD: begin
							if (!tid_in_range || flag_hit || tid_running) begin
								status_q <= ST_ALREADY_QUEUED;
							end else begin
								if (cnt_zero) begin
									head_q <= tid_ix;
								end
								tail_q <= tid_ix;
								cnt_q <= cnt_q + CntW'(1);
							end
						end
						CMD_REMOVE: begin
							if (!tid_in_range || !flag_hit) begin
								status_q <= ST_NOT_QUEUED;
							end else if (head_q == tid_ix) begin
								cnt_q <= cnt_q - CntW'(1);
								if (cnt_gt1) begin
									state_q <= S_POP;
								end
							end else if (cnt_gt1) begin
								walk_q <= head_q;
								steps_q <= CntW'(1);
								state_q <= S_WALK;
							end else begin
								status_q <= ST_NOT_QUEUED;
							end
						end
						CMD_SCHEDULE: begin
							if (cur_valid_q && cnt_zero) begin
								// Alone: the running thread is pushed and popped again.
								head_q <= cur_q;
								tail_q <= cur_q;
							end else if (!cnt_zero) begin
								cur_q <= head_q;
								cur_valid_q <= 1'b1;
								if (cur_valid_q) begin
									tail_q <= cur_q;
									if (!cnt_gt1) begin
										head_q <= cur_q;
									end
								end else begin
									cnt_q <= cnt_q - CntW'(1);
								end
								if (cnt_gt1) begin
									state_q <= S_POP;
								end
							end
						end
						default: begin
						end
					endcase
				end
				S_POP: begin
					head_q <= rd_data_q;
					state_q <= S_RESP;
				end
				S_WALK: begin
					if (rd_data_q == tid_ix) begin
						state_q <= S_SPLICE;
					end else if ((steps_q + CntW'(1)) < cnt_q) begin
						walk_q <= rd_data_q;
						steps_q <= steps_q + CntW'(1);
					end else begin
						status_q <= ST_NOT_QUEUED;
						state_q <= S_RESP;
					end
				end
				S_SPLICE: begin
					if (tail_q == tid_ix) begin
						tail_q <= walk_q;
					end
					cnt_q <= cnt_q - CntW'(1);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_free) begin
						rsp_q.status <= status_q;
						rsp_q.running_valid <= cur_valid_q;
						rsp_q.running_id <= cur_valid_q ? TID_W'(cur_q) : '0;
						rsp_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`RRQ_ASSERT(a_count_bound, clk, arst_n, cnt_q <= CntW'(N))
	`RRQ_ASSERT_NEXT(a_accept_exec, clk, arst_n, req_valid && !req_stall, state_q == S_EXEC)
	`RRQ_ASSERT_IMPL(a_walk_bound, clk, arst_n, state_q == S_WALK, steps_q < cnt_q)
	`RRQ_ASSERT_IMPL(a_walk_not_head, clk, arst_n, state_q == S_WALK, head_q != tid_ix)

endmodule

`default_nettype wire

FILE: tb/round_robin_run_queue_tb.sv
// Self-checking testbench for the round-robin run queue: directed and random requests.
// A shadow run queue predicts every response. Depends on rrq_pkg and the round_robin_run_queue RTL.
`default_nettype none

module round_robin_run_queue_tb;
	import rrq_pkg::*;

	localparam int unsigned NTHREADS = 64;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int unsigned IDLE_LIMIT = 4000;
	localparam int unsigned LONG_HOLD = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	rrq_req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rrq_rsp_t rsp;

	// Requests waiting to be offered and responses that are due, oldest first.
	rrq_req_t req_pend_q[$];
	rrq_rsp_t rsp_due_q[$];

	// Shadow copy of the run queue.
	logic [TID_W-1:0] sh_link [NTHREADS];
	logic sh_queued [NTHREADS];
	logic [TID_W-1:0] sh_head = '0;
	logic [TID_W-1:0] sh_tail = '0;
	int unsigned sh_count = 0;
	logic [TID_W-1:0] sh_run_id = '0;
	logic sh_run_valid = 1'b0;

	int unsigned err_cnt = 0;
	int unsigned hold_req_cnt = 0;

	round_robin_run_queue #(
		.MAX_THREADS(NTHREADS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// Clock and the single reset at the start of the run.
	initial begin
		for (int i = 0; i < NTHREADS; i++) begin
			sh_link[i] = '0;
			sh_queued[i] = 1'b0;
		end
		fork
			forever #5 clk = ~clk;
			begin
				repeat (3) @(posedge clk);
				@(negedge clk);
				arst_n = 1'b1;
			end
		join_none
	end

	// Appends a thread at the tail of the shadow queue.
	function automatic void sh_append(logic [TID_W-1:0] id);
		sh_link[id] = '0;
		if (sh_count == 0) begin
			sh_head = id;
		end else begin
			sh_link[sh_tail] = id;
		end
		sh_tail = id;
		sh_queued[id] = 1'b1;
		sh_count++;
	endfunction

	// Takes the head off the shadow queue; the queue is not empty.
	function automatic logic [TID_W-1:0] sh_take_head();
		logic [TID_W-1:0] id;
		id = sh_head;
		if (sh_count > 1) begin
			sh_head = sh_link[id];
		end
		sh_count--;
		sh_queued[id] = 1'b0;
		return id;
	endfunction

	// Unlinks a thread from anywhere in the shadow queue by walking from the head.
	function automatic logic [ST_W-1:0] sh_unlink(logic [TID_W-1:0] id);
		logic [TID_W-1:0] walk;
		logic [TID_W-1:0] nxt;
		if (!sh_queued[id]) begin
			return ST_NOT_QUEUED;
		end
		if (sh_head == id) begin
			void'(sh_take_head());
			return ST_OK;
		end
		walk = sh_head;
		for (int unsigned steps = 1; steps < sh_count; steps++) begin
			nxt = sh_link[walk];
			if (nxt == id) begin
				sh_link[walk] = sh_link[nxt];
				if (sh_tail == id) begin
					sh_tail = walk;
				end
				sh_queued[id] = 1'b0;
				sh_count--;
				return ST_OK;
			end
			walk = nxt;
		end
		sh_queued[id] = 1'b0;
		return ST_NOT_QUEUED;
	endfunction

	// Applies one request to the shadow queue and returns the response it must give.
	function automatic rrq_rsp_t sh_apply(rrq_req_t r);
		rrq_rsp_t res;
		logic [ST_W-1:0] st;
		st = ST_OK;
		case (r.command)
			CMD_ADD: begin
				if (sh_queued[r.thread_id] || (sh_run_valid && sh_run_id == r.thread_id)) begin
					st = ST_ALREADY_QUEUED;
				end else begin
					sh_append(r.thread_id);
				end
			end
			CMD_REMOVE: begin
				st = sh_unlink(r.thread_id);
			end
			CMD_SCHEDULE: begin
				if (sh_run_valid) begin
					sh_append(sh_run_id);
					sh_run_valid = 1'b0;
				end
				if (sh_count != 0) begin
					sh_run_id = sh_take_head();
					sh_run_valid = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res.status = st;
		res.running_valid = sh_run_valid;
		res.running_id = sh_run_valid ? sh_run_id : '0;
		return res;
	endfunction

	function automatic rrq_req_t mk_req(logic [CMD_W-1:0] cmd, int unsigned id);
		rrq_req_t r;
		r.command = cmd;
		r.thread_id = TID_W'(id);
		return r;
	endfunction

	// Random request; most ids come from a small pool so that adds and removes hit.
	function automatic rrq_req_t rand_req(int unsigned id_hi);
		int unsigned w;
		int unsigned id;
		logic [CMD_W-1:0] cmd;
		w = $urandom_range(0, 99);
		if (w < 40) begin
			cmd = CMD_ADD;
		end else if (w < 70) begin
			cmd = CMD_REMOVE;
		end else if (w < 95) begin
			cmd = CMD_SCHEDULE;
		end else begin
			cmd = CMD_UNUSED;
		end
		if ($urandom_range(0, 99) < 70) begin
			id = $urandom_range(0, id_hi);
		end else begin
			id = $urandom_range(0, NTHREADS - 1);
		end
		return mk_req(cmd, id);
	endfunction

	task automatic send(logic [CMD_W-1:0] cmd, int unsigned id);
		req_pend_q.push_back(mk_req(cmd, id));
	endtask

	// Waits until every request has been taken and every response has come back.
	task automatic wait_drained();
		while (req_pend_q.size() != 0 || req_valid || rsp_due_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// Request driver: bursts of random length with random gaps between them.
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				rsp_due_q.push_back(sh_apply(req));
			end
			if (!req_valid || !req_stall) begin
				if (gap_left != 0) begin
					gap_left--;
					req_valid <= 1'b0;
				end else if (req_pend_q.size() != 0) begin
					req <= req_pend_q.pop_front();
					req_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
							: $urandom_range(1, 12);
						case ($urandom_range(0, 5))
							0, 1: gap_left = 0;
							2, 3, 4: gap_left = $urandom_range(1, 8);
							default: gap_left = $urandom_range(9, 30);
						endcase
					end else begin
						burst_left--;
					end
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response stall pattern: modes that change now and then, plus one long hold-off on request.
	int unsigned hold_left = 0;
	int unsigned hold_seen = 0;
	int unsigned mode_left = 0;
	int unsigned stall_mode = 0;
	int unsigned cyc = 0;

	always @(posedge clk) begin
		cyc++;
		if (mode_left == 0) begin
			mode_left = $urandom_range(97, 300);
			stall_mode = $urandom_range(0, 3);
		end else begin
			mode_left--;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (hold_seen != hold_req_cnt) begin
			hold_seen = hold_req_cnt;
			hold_left = LONG_HOLD;
			rsp_stall <= 1'b1;
		end else begin
			case (stall_mode)
				0: rsp_stall <= 1'b0;
				1: rsp_stall <= ($urandom_range(0, 4) == 0);
				2: rsp_stall <= ($urandom_range(0, 3) != 0);
				default: rsp_stall <= cyc[2];
			endcase
		end
	end

	// Response checker: each taken response against the oldest one due.
	always @(posedge clk) begin : rsp_check
		rrq_rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_due_q.size() == 0) begin
				$display("%0t: unexpected response: status %0d running_valid %0d running_id %0d",
					$time, rsp.status, rsp.running_valid, rsp.running_id);
				err_cnt++;
			end else begin
				want = rsp_due_q.pop_front();
				if (rsp.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, rsp.status);
					err_cnt++;
				end
				if (rsp.running_valid !== want.running_valid) begin
					$display("%0t: running_valid expected %0d actual %0d",
						$time, want.running_valid, rsp.running_valid);
					err_cnt++;
				end
				if (rsp.running_id !== want.running_id) begin
					$display("%0t: running_id expected %0d actual %0d",
						$time, want.running_id, rsp.running_id);
					err_cnt++;
				end
			end
		end
	end

	// Watchdog: ends the run when no request and no response moves for too long.
	int unsigned idle_cyc = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle_cyc = 0;
			end else begin
				idle_cyc++;
			end
			if (idle_cyc >= IDLE_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
				$display("round_robin_run_queue regression: fail");
				$finish;
			end
		end
	end

	// Stimulus: directed cases, then random phases.
	initial begin : stimulus
		int unsigned perm [NTHREADS];
		int unsigned j;
		int unsigned t;
		while (!arst_n) begin
			@(negedge clk);
		end
		@(negedge clk);

		// Empty queue: idle schedule, unused command, remove of an absent thread.
		send(CMD_SCHEDULE, 0);
		send(CMD_UNUSED, 0);
		send(CMD_REMOVE, 0);
		// Extreme ids, an add of a queued thread, removes from the middle and the tail.
		send(CMD_ADD, 0);
		send(CMD_ADD, 63);
		send(CMD_ADD, 0);
		send(CMD_ADD, 21);
		send(CMD_ADD, 42);
		send(CMD_REMOVE, 21);
		send(CMD_REMOVE, 42);
		// The running thread can be neither added nor removed.
		send(CMD_SCHEDULE, 0);
		send(CMD_ADD, 0);
		send(CMD_REMOVE, 0);
		send(CMD_SCHEDULE, 63);
		// Remove of the only queued thread, then rotation with an empty queue.
		send(CMD_REMOVE, 0);
		send(CMD_SCHEDULE, 0);
		send(CMD_ADD, 5);
		send(CMD_ADD, 6);
		send(CMD_REMOVE, 5);
		send(CMD_UNUSED, 63);
		send(CMD_REMOVE, 63);
		send(CMD_SCHEDULE, 0);
		send(CMD_ADD, 42);
		send(CMD_REMOVE, 42);
		send(CMD_REMOVE, 6);
		// Sender pauses here until every response has come.
		wait_drained();

		for (int i = 0; i < 400; i++) begin
			req_pend_q.push_back(rand_req(15));
		end
		wait_drained();

		// Long receiver hold-off while requests keep coming.
		hold_req_cnt++;
		for (int i = 0; i < 30; i++) begin
			req_pend_q.push_back(rand_req(7));
		end
		wait_drained();

		// Fill the queue with every thread, churn it, then empty it in random order.
		for (int i = 0; i < NTHREADS; i++) begin
			perm[i] = i;
		end
		for (int i = NTHREADS - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		for (int i = 0; i < NTHREADS; i++) begin
			send(CMD_ADD, perm[i]);
		end
		for (int i = 0; i < 100; i++) begin
			t = $urandom_range(0, 9);
			if (t < 5) begin
				send(CMD_REMOVE, $urandom_range(0, NTHREADS - 1));
			end else if (t < 9) begin
				send(CMD_SCHEDULE, $urandom_range(0, NTHREADS - 1));
			end else begin
				send(CMD_ADD, $urandom_range(0, NTHREADS - 1));
			end
		end
		for (int i = NTHREADS - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			t = perm[i];
			perm[i] = perm[j];
			perm[j] = t;
		end
		for (int i = 0; i < NTHREADS; i++) begin
			send(CMD_REMOVE, perm[i]);
		end

		for (int i = 0; i < 450; i++) begin
			req_pend_q.push_back(rand_req(($urandom_range(0, 1) == 0) ? 7 : 31));
		end
		wait_drained();

		repeat (100) @(negedge clk);
		if (err_cnt == 0) begin
			$display("round_robin_run_queue regression: pass");
		end else begin
			$display("round_robin_run_queue regression: fail");
		end
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/rrq_pkg.sv
hw/rtl/rrq_flags.sv
hw/rtl/round_robin_run_queue.sv
tb/round_robin_run_queue_tb.sv
